@@ rtl/dncd_pkg.sv @@
package dncd_pkg;

  // Control that travels beside each pipeline stage
  typedef struct packed {
    logic valid;
    logic no_date;
  } dncd_ctl_t;

  // Cycle lengths in days
  localparam logic [17:0] DAYS_400 = 18'd146097;
  localparam logic [15:0] DAYS_100 = 16'd36524;
  localparam logic [10:0] DAYS_4   = 11'd1461;
  localparam logic [8:0]  DAYS_1   = 9'd365;

  // 2^31 + BIAS_DAYS = 14700 * DAYS_400, the offset added to day_number
  localparam logic [32:0] BIAS_DAYS = 33'd142252;
  // floor(2^34 / 146097), applied to the count shifted down by 10
  localparam logic [16:0] RECIP_400 = 17'd117592;
  // ceil(2^26 / 1461)
  localparam logic [15:0] RECIP_4   = 16'd45934;

  localparam logic [23:0] YEARS_400 = 24'd400;
  localparam logic [23:0] YEARS_100 = 24'd100;
  // 400 * 14700 - 1
  localparam logic [23:0] YEAR_BIAS = 24'd5879999;

  // First day of month m (0 = January) within the year
  function automatic logic [8:0] month_start(input logic [3:0] m, input logic leap);
    logic [8:0] base;
    case (m)
      4'd0:    base = 9'd0;
      4'd1:    base = 9'd31;
      4'd2:    base = 9'd59;
      4'd3:    base = 9'd90;
      4'd4:    base = 9'd120;
      4'd5:    base = 9'd151;
      4'd6:    base = 9'd181;
      4'd7:    base = 9'd212;
      4'd8:    base = 9'd243;
      4'd9:    base = 9'd273;
      4'd10:   base = 9'd304;
      4'd11:   base = 9'd334;
      default: base = 9'd0;
    endcase
    if (leap && m >= 4'd2) begin
      base = base + 9'd1;
    end
    return base;
  endfunction

endpackage

@@ rtl/dncd_in_if.sv @@
interface dncd_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] day_number;
  logic               no_date;

  modport source (output valid, output day_number, output no_date, input ready);
  modport sink (input valid, input day_number, input no_date, output ready);
endinterface

@@ rtl/dncd_out_if.sv @@
interface dncd_out_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] year;
  logic [3:0]         month;
  logic [4:0]         day_of_month;
  logic               status;

  modport source (output valid, output year, output month, output day_of_month,
                  output status, input ready);
  modport sink (input valid, input year, input month, input day_of_month,
                input status, output ready);
endinterface

@@ rtl/day_number_to_calendar_date_core.sv @@
// Channel   Dir  Payload                                   Handshake
// day_in    in   day_number[31:0] signed, no_date          valid / ready
// date_out  out  year[23:0] signed, month, day_of_month,    valid / ready
//                status
//
// Nine-stage pipeline: one item per cycle while the output item is taken.
// Stages: 400-year division (3), 100-year split, 4-year estimate, 4-year
// remainder, 1-year split, month search, day and output register.
// rst (synchronous) clears the control bits (valid, no_date) only.
// When the output item is not taken, the whole pipeline holds and
// day_in.ready drops; empty stages are not squeezed out.
module day_number_to_calendar_date_core import dncd_pkg::*; (
  input logic        clk,
  input logic        rst,
  dncd_in_if.sink    day_in,
  dncd_out_if.source date_out
);

  logic      en;
  dncd_ctl_t ctl_in;
  dncd_ctl_t ctl3;
  logic [14:0] q3;
  logic [17:0] r3;

  dncd_ctl_t   ctl4;
  logic [15:0] r4;
  logic [1:0]  n100_4;
  logic [23:0] y4;

  dncd_ctl_t   ctl5;
  logic [15:0] r5;
  logic [4:0]  n4_5;
  logic [1:0]  n100_5;
  logic [23:0] y5;

  dncd_ctl_t   ctl6;
  logic [10:0] r6;
  logic        leap_ok6;
  logic [23:0] y6;

  dncd_ctl_t   ctl7;
  logic [8:0]  r7;
  logic        leap7;
  logic [23:0] y7;

  dncd_ctl_t   ctl8;
  logic [8:0]  r8;
  logic [3:0]  m8;
  logic        leap8;
  logic [23:0] y8;

  logic        ovalid;
  logic [23:0] oyear;
  logic [3:0]  omonth;
  logic [4:0]  oday;
  logic        ostatus;

  logic [1:0]  n100_next;
  logic [17:0] sub100;
  logic [31:0] prod5;
  logic [1:0]  n1_next;
  logic [10:0] sub1;
  logic [3:0]  m_next;
  logic [8:0]  day_next;

  assign en           = !ovalid || date_out.ready;
  assign day_in.ready = en;
  assign ctl_in       = '{valid: day_in.valid, no_date: day_in.no_date};

  dncd_div400 u_div400 (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .ctl_in     (ctl_in),
    .day_number (day_in.day_number),
    .ctl_out    (ctl3),
    .q          (q3),
    .r          (r3)
  );

  // 100-year cycles, at most three
  always_comb begin
    if (r3 >= 18'd109572) begin
      n100_next = 2'd3;
      sub100    = 18'd109572;
    end else if (r3 >= 18'd73048) begin
      n100_next = 2'd2;
      sub100    = 18'd73048;
    end else if (r3 >= 18'(DAYS_100)) begin
      n100_next = 2'd1;
      sub100    = 18'(DAYS_100);
    end else begin
      n100_next = 2'd0;
      sub100    = 18'd0;
    end
  end

  // 4-year cycles by reciprocal; exact for remainders up to 36524
  assign prod5 = 32'(r4) * 32'(RECIP_4);

  // single years, at most three
  always_comb begin
    if (r6 >= 11'd1095) begin
      n1_next = 2'd3;
      sub1    = 11'd1095;
    end else if (r6 >= 11'd730) begin
      n1_next = 2'd2;
      sub1    = 11'd730;
    end else if (r6 >= 11'(DAYS_1)) begin
      n1_next = 2'd1;
      sub1    = 11'(DAYS_1);
    end else begin
      n1_next = 2'd0;
      sub1    = 11'd0;
    end
  end

  // month index: count of month starts after January at or below the day of year
  always_comb begin
    m_next = 4'd0;
    for (int k = 1; k < 12; k++) begin
      if (month_start(4'(k), leap7) <= r7) begin
        m_next = m_next + 4'd1;
      end
    end
  end

  assign day_next = r8 - month_start(m8, leap8) + 9'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl4   <= '0;
      ctl5   <= '0;
      ctl6   <= '0;
      ctl7   <= '0;
      ctl8   <= '0;
      ovalid <= 1'b0;
    end else if (en) begin
      ctl4   <= ctl3;
      ctl5   <= ctl4;
      ctl6   <= ctl5;
      ctl7   <= ctl6;
      ctl8   <= ctl7;
      ovalid <= ctl8.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r4     <= 16'(r3 - sub100);
      n100_4 <= n100_next;
      y4     <= (24'(q3) * YEARS_400) - YEAR_BIAS;

      r5     <= r4;
      n4_5   <= prod5[30:26];
      n100_5 <= n100_4;
      y5     <= y4 + 24'(n100_4) * YEARS_100;

      r6       <= 11'(r5 - 16'(n4_5) * 16'(DAYS_4));
      // a century year is common unless it closes the 400-year cycle
      leap_ok6 <= (n4_5 != 5'd24) || (n100_5 == 2'd3);
      y6       <= y5 + {17'd0, n4_5, 2'b00};

      r7    <= 9'(r6 - sub1);
      leap7 <= (n1_next == 2'd3) && leap_ok6;
      y7    <= y6 + 24'(n1_next);

      r8    <= r7;
      m8    <= m_next;
      leap8 <= leap7;
      y8    <= y7;

      if (ctl8.no_date) begin
        oyear   <= 24'd1;
        omonth  <= 4'd1;
        oday    <= 5'd1;
        ostatus <= 1'b1;
      end else begin
        oyear   <= y8;
        omonth  <= m8 + 4'd1;
        oday    <= day_next[4:0];
        ostatus <= 1'b0;
      end
    end
  end

  assign date_out.valid        = ovalid;
  assign date_out.year         = oyear;
  assign date_out.month        = omonth;
  assign date_out.day_of_month = oday;
  assign date_out.status       = ostatus;

endmodule

@@ rtl/dncd_div400.sv @@
// Floor division of the biased day count by 146097, three stages:
// estimate by reciprocal, remainder, one-step correction.
module dncd_div400 import dncd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  dncd_ctl_t          ctl_in,
  input  logic signed [31:0] day_number,
  output dncd_ctl_t          ctl_out,
  output logic [14:0]        q,
  output logic [17:0]        r
);

  dncd_ctl_t   ctl1;
  dncd_ctl_t   ctl2;
  logic [32:0] w1;
  logic [14:0] qe1;
  logic [18:0] r2;
  logic [14:0] q2;

  logic [31:0] u;
  logic [32:0] w_next;
  logic [39:0] prod1;
  logic [32:0] prod2;
  logic [32:0] diff2;
  logic        over;

  // w is nonnegative; true quotient is floor(w / 146097) - 14700
  assign u      = {~day_number[31], day_number[30:0]};
  assign w_next = {1'b0, u} + BIAS_DAYS;
  assign prod1  = 40'(w_next[32:10]) * 40'(RECIP_400);

  // estimate is low by at most one
  assign prod2 = 33'(qe1) * 33'(DAYS_400);
  assign diff2 = w1 - prod2;

  assign over = r2 >= 19'(DAYS_400);

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1    <= '0;
      ctl2    <= '0;
      ctl_out <= '0;
    end else if (en) begin
      ctl1    <= ctl_in;
      ctl2    <= ctl1;
      ctl_out <= ctl2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      w1  <= w_next;
      qe1 <= prod1[38:24];
      r2  <= diff2[18:0];
      q2  <= qe1;
      if (over) begin
        r <= 18'(r2 - 19'(DAYS_400));
        q <= q2 + 15'd1;
      end else begin
        r <= r2[17:0];
        q <= q2;
      end
    end
  end

endmodule
